FILE: sv/tcs_pkg.sv
// Types, constants and reply tables shared by the telnet command stripper.
package tcs_pkg;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_AYT  = 8'd246;
  localparam logic [7:0] B_SE   = 8'd240;

  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_NAWS   = 8'd31;
  localparam logic [7:0] OPT_TSPEED = 8'd32;

  localparam int unsigned SeqDepth = 16;
  localparam int unsigned IdxW     = $clog2(SeqDepth);

  localparam logic [IdxW-1:0] LAST_DATA   = IdxW'(0);
  localparam logic [IdxW-1:0] LAST_YES    = IdxW'(8);
  localparam logic [IdxW-1:0] LAST_NAWS   = IdxW'(8);
  localparam logic [IdxW-1:0] LAST_TSPEED = IdxW'(13);
  localparam logic [IdxW-1:0] LAST_TTYPE  = IdxW'(10);
  localparam logic [IdxW-1:0] LAST_CMD    = IdxW'(2);

  localparam logic [7:0] YES_SEQ [SeqDepth] = '{
    8'h0D, 8'h0A, 8'h5B, 8'h59, 8'h65, 8'h73, 8'h5D, 8'h0D,
    8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] TSPEED_SEQ [SeqDepth] = '{
    8'd255, 8'd250, 8'd32, 8'h39, 8'h36, 8'h30, 8'h30, 8'h2C,
    8'h39, 8'h36, 8'h30, 8'h30, 8'd255, 8'd240, 8'h00, 8'h00
  };

  localparam logic [7:0] TTYPE_SEQ [SeqDepth] = '{
    8'd255, 8'd250, 8'd24, 8'h00, 8'h56, 8'h54, 8'h31, 8'h30,
    8'h30, 8'd255, 8'd240, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [2:0] {
    PS_DATA,
    PS_IAC,
    PS_DO,
    PS_DONT,
    PS_WILL,
    PS_WONT,
    PS_SB,
    PS_SBIAC
  } parse_state_e;

  typedef enum logic [2:0] {
    JK_DATA,
    JK_YES,
    JK_NAWS,
    JK_TSPEED,
    JK_TTYPE,
    JK_WONT,
    JK_DONT
  } job_kind_e;

  typedef struct packed {
    logic      valid;
    job_kind_e kind;
    logic [7:0] arg;
  } job_t;

  typedef struct packed {
    logic      busy;
    job_kind_e kind;
  } emit_status_t;

  function automatic logic [IdxW-1:0] seq_last(input job_kind_e kind);
    logic [IdxW-1:0] r;
    case (kind)
      JK_DATA:   r = LAST_DATA;
      JK_YES:    r = LAST_YES;
      JK_NAWS:   r = LAST_NAWS;
      JK_TSPEED: r = LAST_TSPEED;
      JK_TTYPE:  r = LAST_TTYPE;
      JK_WONT:   r = LAST_CMD;
      JK_DONT:   r = LAST_CMD;
      default:   r = LAST_DATA;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] win_byte(input logic [7:0] v);
    return (v == 8'd255) ? 8'd254 : v;
  endfunction

  function automatic logic [7:0] seq_byte(input job_kind_e kind, input logic [IdxW-1:0] idx,
                                          input logic [7:0] arg, input logic [7:0] cols,
                                          input logic [7:0] rows);
    logic [7:0] r;
    r = 8'h00;
    case (kind)
      JK_DATA:   r = arg;
      JK_YES:    r = YES_SEQ[idx];
      JK_TSPEED: r = TSPEED_SEQ[idx];
      JK_TTYPE:  r = TTYPE_SEQ[idx];
      JK_NAWS: begin
        case (idx)
          IdxW'(0): r = B_IAC;
          IdxW'(1): r = B_SB;
          IdxW'(2): r = OPT_NAWS;
          IdxW'(4): r = win_byte(cols);
          IdxW'(6): r = win_byte(rows);
          IdxW'(7): r = B_IAC;
          IdxW'(8): r = B_SE;
          default:  r = 8'h00;
        endcase
      end
      JK_WONT: begin
        case (idx)
          IdxW'(0): r = B_IAC;
          IdxW'(1): r = B_WONT;
          default:  r = arg;
        endcase
      end
      JK_DONT: begin
        case (idx)
          IdxW'(0): r = B_IAC;
          IdxW'(1): r = B_DONT;
          default:  r = arg;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/tcs_parser.sv
// Telnet parser state machine: decodes each received byte and raises an output job where one is due.
module tcs_parser import tcs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   rx_byte_i,
  output job_t         job_o,
  output parse_state_e state_o
);

  parse_state_e state_q, state_d;
  job_t         job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_DATA;
    end else if (accept_i) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = PS_DATA;
    case (state_q)
      PS_DATA: begin
        state_d = (rx_byte_i == B_IAC) ? PS_IAC : PS_DATA;
      end
      PS_IAC: begin
        case (rx_byte_i)
          B_DO:    state_d = PS_DO;
          B_DONT:  state_d = PS_DONT;
          B_WILL:  state_d = PS_WILL;
          B_WONT:  state_d = PS_WONT;
          B_SB:    state_d = PS_SB;
          default: state_d = PS_DATA;
        endcase
      end
      PS_SB: begin
        state_d = (rx_byte_i == B_IAC) ? PS_SBIAC : PS_SB;
      end
      PS_SBIAC: begin
        state_d = (rx_byte_i == B_SE) ? PS_DATA : PS_SB;
      end
      default: state_d = PS_DATA;
    endcase
  end

  always_comb begin
    job.valid = 1'b0;
    job.kind  = JK_DATA;
    job.arg   = rx_byte_i;
    case (state_q)
      PS_DATA: begin
        job.valid = (rx_byte_i != B_IAC);
      end
      PS_IAC: begin
        if (rx_byte_i == B_IAC) begin
          job.valid = 1'b1;
        end else if (rx_byte_i == B_AYT) begin
          job.valid = 1'b1;
          job.kind  = JK_YES;
        end
      end
      PS_DO: begin
        job.valid = 1'b1;
        job.kind  = JK_WONT;
        case (rx_byte_i)
          OPT_SGA, OPT_BINARY: job.valid = 1'b0;
          OPT_NAWS:            job.kind  = JK_NAWS;
          OPT_TSPEED:          job.kind  = JK_TSPEED;
          OPT_TTYPE:           job.kind  = JK_TTYPE;
          default:             job.kind  = JK_WONT;
        endcase
      end
      PS_DONT: begin
        job.valid = 1'b1;
        job.kind  = JK_WONT;
      end
      PS_WILL: begin
        job.valid = !(rx_byte_i inside {OPT_BINARY, OPT_ECHO, OPT_SGA, OPT_NAWS});
        job.kind  = JK_DONT;
      end
      default: job.valid = 1'b0;
    endcase
  end

  assign job_o   = '{valid: job.valid & accept_i, kind: job.kind, arg: job.arg};
  assign state_o = state_q;

endmodule

FILE: sv/tcs_emitter.sv
// Job register and sequencer that plays each job out into the output register.
module tcs_emitter import tcs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  job_t         job_i,
  output logic         job_ready_o,
  input  logic [7:0]   cols_i,
  input  logic [7:0]   rows_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [7:0]   out_byte_o,
  output logic         out_dest_o,
  output logic         last_o,
  output emit_status_t status_o
);

  logic            job_valid_q, job_valid_d;
  job_kind_e       kind_q, kind_d;
  logic [7:0]      arg_q, arg_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_dest_q, out_dest_d;
  logic            out_last_q, out_last_d;
  logic            out_load, step, job_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    arg_q      <= arg_d;
    idx_q      <= idx_d;
    out_byte_q <= out_byte_d;
    out_dest_q <= out_dest_d;
    out_last_q <= out_last_d;
  end

  assign out_load    = !out_valid_q || out_ready_i;
  assign step        = job_valid_q && out_load;
  assign job_end     = (idx_q == seq_last(kind_q));
  assign job_ready_o = !job_valid_q || (step && job_end);

  always_comb begin
    job_valid_d = job_valid_q;
    kind_d      = kind_q;
    arg_d       = arg_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_dest_d  = out_dest_q;
    out_last_d  = out_last_q;
    if (step) begin
      out_valid_d = 1'b1;
      out_byte_d  = seq_byte(kind_q, idx_q, arg_q, cols_i, rows_i);
      out_dest_d  = (kind_q != JK_DATA);
      out_last_d  = job_end;
      idx_d       = idx_q + IdxW'(1);
      if (job_end) begin
        job_valid_d = 1'b0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (job_i.valid) begin
      job_valid_d = 1'b1;
      kind_d      = job_i.kind;
      arg_d       = job_i.arg;
      idx_d       = '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_dest_o  = out_dest_q;
  assign last_o      = out_last_q;
  assign status_o    = '{busy: job_valid_q, kind: kind_q};

endmodule

FILE: sv/telnet_command_stripper.sv
// Top level of the telnet command stripper: config registers, parser and emitter.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------
//  rx in     | in_valid_i / in_ready_o    | rx_byte_i[7:0]
//  result    | out_valid_o / out_ready_i  | out_byte_o[7:0], out_dest_o, last_o
//  config    | psel, penable, pwrite      | paddr[2:0], pwdata, prdata (pready = 1)
//
// A byte is decoded into the job register when it is accepted, and the sequencer then
// plays it out into the output register; plain data flows at one item per cycle
// while the output is not stalled. A reply of N bytes holds the job register until
// all N are shown, one output byte a cycle while the output is not stalled.
// Reset clears the parser to data state and the window size to 80 by 24.
// A stalled output holds the result and, once the job register is full, in_ready_o.
module telnet_command_stripper import tcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_dest_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]   cols_q, rows_q;
  logic         accept;
  logic         cfg_write;
  job_t         job;
  parse_state_e pstate;
  emit_status_t estatus;

  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = {24'h0, paddr[2] ? rows_q : cols_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 8'd80;
      rows_q <= 8'd24;
    end else if (cfg_write) begin
      if (paddr[2]) begin
        rows_q <= pwdata[7:0];
      end else begin
        cols_q <= pwdata[7:0];
      end
    end
  end

  assign accept = in_valid_i && in_ready_o;

  tcs_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .job_o     (job),
    .state_o   (pstate)
  );

  tcs_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_ready_o (in_ready_o),
    .cols_i      (cols_q),
    .rows_i      (rows_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_dest_o  (out_dest_o),
    .last_o      (last_o),
    .status_o    (estatus)
  );

`ifndef NO_ASSERTIONS
  a_data_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_dest_o |-> last_o)
    else $error("host data item not marked last");

  a_data_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && pstate == PS_DATA && rx_byte_i != B_IAC
    |=> estatus.busy && estatus.kind == JK_DATA)
    else $error("plain data byte did not load a data job");

  a_subneg_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (pstate == PS_SB || pstate == PS_SBIAC) |=> !estatus.busy)
    else $error("subnegotiation byte produced a job");
`endif

endmodule

FILE: bench/tb_telnet_command_stripper.sv
// Self-checking testbench for the telnet command stripper: byte stream in, data and replies out.
`timescale 1ns / 100ps

module tb_telnet_command_stripper;
  import tcs_pkg::*;

  localparam logic [2:0] ADDR_COLUMNS = 3'd0;
  localparam logic [2:0] ADDR_ROWS    = 3'd4;
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam logic [7:0] OPENING [33] = '{
    B_IAC, B_DO, OPT_NAWS,
    8'h00, B_IAC, B_IAC, 8'hFE,
    B_IAC, B_AYT,
    B_IAC, B_DO, OPT_TSPEED,
    B_IAC, B_DO, OPT_TTYPE,
    B_IAC, B_DO, OPT_BINARY,
    B_IAC, B_WILL, 8'h99,
    B_IAC, B_DONT, 8'h7F,
    B_IAC, B_SB, OPT_TTYPE, B_IAC, 8'h41, B_IAC, B_SE,
    B_IAC, 8'hF1
  };

  typedef struct packed {
    logic [7:0] val;
    logic       to_peer;
    logic       is_last;
  } out_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        out_dest_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  logic [7:0]   pending_rx [$];
  out_item_t    due_bytes [$];
  logic [7:0]   reply [$];
  out_item_t    head;
  parse_state_e parse_st = PS_DATA;
  logic [7:0]   win_cols = 8'd80;
  logic [7:0]   win_rows = 8'd24;
  logic         calm = 1'b0;
  int unsigned  send_gap = 0;
  int unsigned  recv_gap = 0;
  int unsigned  cycles = 0;
  int unsigned  errors = 0;
  int unsigned  rx_count = 0;
  int unsigned  checked = 0;
  int unsigned  peer_count = 0;

  telnet_command_stripper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .out_dest_o (out_dest_o),
    .last_o     (last_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) reply.push_back(s[i]);
  endtask

  task automatic add_cmd(input logic [7:0] verb, input logic [7:0] opt);
    reply.push_back(B_IAC);
    reply.push_back(verb);
    reply.push_back(opt);
  endtask

  task automatic strip_byte(input logic [7:0] c);
    logic to_peer;
    int i;
    reply.delete();
    to_peer = 1'b1;
    case (parse_st)
      PS_DATA: begin
        if (c == B_IAC) begin
          parse_st = PS_IAC;
        end else begin
          reply.push_back(c);
          to_peer = 1'b0;
        end
      end
      PS_IAC: begin
        parse_st = PS_DATA;
        if (c == B_IAC) begin
          reply.push_back(c);
          to_peer = 1'b0;
        end else if (c == B_AYT) begin
          reply.push_back(8'h0D);
          reply.push_back(8'h0A);
          add_text("[Yes]");
          reply.push_back(8'h0D);
          reply.push_back(8'h0A);
        end else if (c == B_DO) begin
          parse_st = PS_DO;
        end else if (c == B_DONT) begin
          parse_st = PS_DONT;
        end else if (c == B_WILL) begin
          parse_st = PS_WILL;
        end else if (c == B_WONT) begin
          parse_st = PS_WONT;
        end else if (c == B_SB) begin
          parse_st = PS_SB;
        end
      end
      PS_DO: begin
        if (!(c == OPT_SGA || c == OPT_BINARY)) begin
          if (c == OPT_NAWS) begin
            reply.push_back(B_IAC);
            reply.push_back(B_SB);
            reply.push_back(OPT_NAWS);
            reply.push_back(8'h00);
            reply.push_back((win_cols == 8'hFF) ? 8'hFE : win_cols);
            reply.push_back(8'h00);
            reply.push_back((win_rows == 8'hFF) ? 8'hFE : win_rows);
            reply.push_back(B_IAC);
            reply.push_back(B_SE);
          end else if (c == OPT_TSPEED) begin
            reply.push_back(B_IAC);
            reply.push_back(B_SB);
            reply.push_back(OPT_TSPEED);
            add_text("9600,9600");
            reply.push_back(B_IAC);
            reply.push_back(B_SE);
          end else if (c == OPT_TTYPE) begin
            reply.push_back(B_IAC);
            reply.push_back(B_SB);
            reply.push_back(OPT_TTYPE);
            reply.push_back(8'h00);
            add_text("VT100");
            reply.push_back(B_IAC);
            reply.push_back(B_SE);
          end else begin
            add_cmd(B_WONT, c);
          end
        end
        parse_st = PS_DATA;
      end
      PS_DONT: begin
        add_cmd(B_WONT, c);
        parse_st = PS_DATA;
      end
      PS_WILL: begin
        if (!(c == OPT_SGA || c == OPT_BINARY || c == OPT_ECHO || c == OPT_NAWS))
          add_cmd(B_DONT, c);
        parse_st = PS_DATA;
      end
      PS_WONT: parse_st = PS_DATA;
      PS_SB: begin
        if (c == B_IAC) parse_st = PS_SBIAC;
      end
      default: parse_st = (c == B_SE) ? PS_DATA : PS_SB;
    endcase
    for (i = 0; i < reply.size(); i++) begin
      due_bytes.push_back('{reply[i], to_peer, (i == reply.size() - 1)});
      if (to_peer) peer_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        strip_byte(rx_byte_i);
        rx_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_rx.size() != 0) begin
          if (!calm && $urandom_range(0, 9) == 0) begin
            in_valid_i <= 1'b0;
            send_gap <= $urandom_range(0, 7);
          end else begin
            in_valid_i <= 1'b1;
            rx_byte_i <= pending_rx.pop_front();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        checked++;
        if (due_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected output byte %02h dest %0d last %0d",
                   $time, out_byte_o, out_dest_o, last_o);
        end else begin
          head = due_bytes.pop_front();
          if (out_byte_o !== head.val) begin
            errors++;
            $display("%0t: out_byte expected %02h actual %02h", $time, head.val, out_byte_o);
          end
          if (out_dest_o !== head.to_peer) begin
            errors++;
            $display("%0t: out_dest expected %0d actual %0d", $time, head.to_peer, out_dest_o);
          end
          if (last_o !== head.is_last) begin
            errors++;
            $display("%0t: last expected %0d actual %0d", $time, head.is_last, last_o);
          end
        end
      end
      if (recv_gap != 0) begin
        out_ready_i <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        recv_gap <= $urandom_range(0, 7);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d output bytes outstanding", $time, due_bytes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_window(input logic [2:0] addr, input logic [7:0] value);
    logic [31:0] w;
    w = $urandom();
    w[7:0] = value;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= w;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_COLUMNS) win_cols = value;
    else win_rows = value;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_rx.size() != 0 || in_valid_i || due_bytes.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic pick_option(output logic [7:0] opt);
    case ($urandom_range(0, 11))
      0: opt = OPT_BINARY;
      1: opt = OPT_ECHO;
      2: opt = OPT_SGA;
      3: opt = OPT_TTYPE;
      4: opt = OPT_NAWS;
      5: opt = OPT_TSPEED;
      default: opt = 8'($urandom_range(0, 255));
    endcase
  endtask

  task automatic queue_chunk();
    logic [7:0] b;
    int n;
    int i;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: pending_rx.push_back(8'($urandom_range(0, 254)));
      8: pending_rx.push_back(8'($urandom_range(0, 255)));
      9: begin
        pending_rx.push_back(B_IAC);
        pending_rx.push_back(B_IAC);
      end
      10: begin
        pending_rx.push_back(B_IAC);
        pending_rx.push_back(B_AYT);
      end
      11, 12: begin
        pick_option(b);
        pending_rx.push_back(B_IAC);
        pending_rx.push_back(B_DO);
        pending_rx.push_back(b);
      end
      13: begin
        pending_rx.push_back(B_IAC);
        pending_rx.push_back(B_DONT);
        pending_rx.push_back(8'($urandom_range(0, 255)));
      end
      14: begin
        pick_option(b);
        pending_rx.push_back(B_IAC);
        pending_rx.push_back(B_WILL);
        pending_rx.push_back(b);
      end
      15: begin
        pending_rx.push_back(B_IAC);
        pending_rx.push_back(B_WONT);
        pending_rx.push_back(8'($urandom_range(0, 255)));
      end
      16, 17: begin
        pending_rx.push_back(B_IAC);
        pending_rx.push_back(B_SB);
        pending_rx.push_back(8'($urandom_range(0, 255)));
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) begin
            do b = 8'($urandom_range(0, 255));
            while (b == B_SE);
            pending_rx.push_back(B_IAC);
            pending_rx.push_back(b);
          end else begin
            pending_rx.push_back(8'($urandom_range(0, 254)));
          end
        end
        pending_rx.push_back(B_IAC);
        pending_rx.push_back(B_SE);
      end
      18: begin
        do b = 8'($urandom_range(0, 255));
        while (b == B_IAC || b == B_AYT || b == B_DO || b == B_DONT ||
               b == B_WILL || b == B_WONT || b == B_SB);
        pending_rx.push_back(B_IAC);
        pending_rx.push_back(b);
      end
      default: begin
        pending_rx.push_back(B_IAC);
        case ($urandom_range(0, 3))
          0: pending_rx.push_back(B_DO);
          1: pending_rx.push_back(B_DONT);
          2: pending_rx.push_back(B_WILL);
          default: pending_rx.push_back(B_WONT);
        endcase
      end
    endcase
  endtask

  task automatic random_phase(input int unsigned count);
    @(negedge clk_i);
    pending_rx.push_back(B_IAC);
    pending_rx.push_back(B_DO);
    pending_rx.push_back(OPT_NAWS);
    while (pending_rx.size() < count) queue_chunk();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    foreach (OPENING[i]) pending_rx.push_back(OPENING[i]);
    drain();

    write_window(ADDR_COLUMNS, 8'd1);
    write_window(ADDR_ROWS, 8'd254);
    random_phase(25);
    drain();

    write_window(ADDR_COLUMNS, 8'd255);
    write_window(ADDR_ROWS, 8'd0);
    random_phase(25);
    drain();

    write_window(ADDR_COLUMNS, 8'($urandom_range(1, 254)));
    write_window(ADDR_ROWS, 8'($urandom_range(1, 254)));
    random_phase(22);
    drain();

    write_window(ADDR_COLUMNS, 8'd254);
    write_window(ADDR_ROWS, 8'd1);
    @(negedge clk_i);
    calm = 1'b1;
    random_phase(22);
    drain();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d telnet bytes over five window sizes; checked %0d output bytes,",
             rx_count, checked);
    $display("%0d of them replies to the peer.", peer_count);
    if (errors == 0 && due_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
